### hw/rtl/pbs_pkg.sv
// Shared types, mode and command codes, and helpers of the pump and bypass sequencer.
`default_nettype none

package pbs_pkg;

  // Field and counter widths.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CNT_W   = 26;

  // Milliseconds in one second; second-based limits are scaled by it.
  localparam int unsigned MS_PER_SECOND = 1000;
  localparam int unsigned LIM_W = CFG_W + $clog2(MS_PER_SECOND + 1);
  localparam int unsigned CMP_W = (LIM_W > CNT_W) ? LIM_W : CNT_W;

  // Stream word widths, rounded up to whole bytes.
  localparam int unsigned IN_BITS   = OP_W + 2;
  localparam int unsigned OUT_BITS  = MODE_W + 4;
  localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Modes.
  localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PRIME = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RUN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLOW  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_MIX   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_DIS   = 3'd7;

  // Commands.
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_START    = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
  localparam logic [OP_W-1:0] OP_DISABLE  = 3'd3;
  localparam logic [OP_W-1:0] OP_BLOWOFF  = 3'd4;
  localparam logic [OP_W-1:0] OP_MIX      = 3'd5;
  localparam logic [OP_W-1:0] OP_BYP_ON   = 3'd6;
  localparam logic [OP_W-1:0] OP_BYP_OFF  = 3'd7;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_PRIME_S   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_RUN_S     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_BLOW_S    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_OPEN_S    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_CLOSE_MS  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_EN_AT_RST = 3'd5;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] PRIME_S_RST  = 16'd10;
  localparam logic [CFG_W-1:0] RUN_S_RST    = 16'd120;
  localparam logic [CFG_W-1:0] BLOW_S_RST   = 16'd3;
  localparam logic [CFG_W-1:0] OPEN_S_RST   = 16'd600;
  localparam logic [CFG_W-1:0] CLOSE_MS_RST = 16'd600;

  typedef struct packed {
    logic [CFG_W-1:0] prime_s;
    logic [CFG_W-1:0] run_s;
    logic [CFG_W-1:0] blow_s;
    logic [CFG_W-1:0] open_s;
    logic [CFG_W-1:0] close_ms;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            reenable;
    logic            keep_open;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              enabled;
    logic [CNT_W-1:0]  elapsed;
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              pump_drive;
    logic              bypass_drive;
    logic              enabled;
    logic              timed_out;
  } result_t;

  // Enable flag after entering mode m.
  function automatic logic entry_enable(input logic [MODE_W-1:0] m, input logic en);
    logic r;
    r = en;
    if (m inside {MODE_IDLE, MODE_RUN, MODE_MIX}) begin
      r = 1'b1;
    end else if (m == MODE_DIS) begin
      r = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pbs_cfg_regs.sv
// Configuration register file of the pump and bypass sequencer.
`default_nettype none

module pbs_cfg_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  input  wire logic [pbs_pkg::IDX_W-1:0] cfg_index_i,
  input  wire logic [pbs_pkg::CFG_W-1:0] cfg_data_i,
  output pbs_pkg::cfg_t                  cfg_o
);
  import pbs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRIME_S:  cfg_d.prime_s  = cfg_data_i;
        CFG_RUN_S:    cfg_d.run_s    = cfg_data_i;
        CFG_BLOW_S:   cfg_d.blow_s   = cfg_data_i;
        CFG_OPEN_S:   cfg_d.open_s   = cfg_data_i;
        CFG_CLOSE_MS: cfg_d.close_ms = cfg_data_i;
        // The start-mode selector has no register here; reset always starts with
        // the pump enabled, so a write to it has no visible effect.
        CFG_EN_AT_RST: cfg_d = cfg_q;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prime_s  <= PRIME_S_RST;
      cfg_q.run_s    <= RUN_S_RST;
      cfg_q.blow_s   <= BLOW_S_RST;
      cfg_q.open_s   <= OPEN_S_RST;
      cfg_q.close_ms <= CLOSE_MS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/pbs_mode_logic.sv
// Next-state and result logic of the pump and bypass sequencer for one word.
`default_nettype none

module pbs_mode_logic (
  input  wire pbs_pkg::state_t  state_i,
  input  wire pbs_pkg::item_t   item_i,
  input  wire pbs_pkg::cfg_t    cfg_i,
  output pbs_pkg::state_t  state_o,
  output pbs_pkg::result_t res_o
);
  import pbs_pkg::*;

  logic [CFG_W-1:0]  sec_sel;
  logic [CMP_W-1:0]  limit;
  logic              has_limit;
  logic [CNT_W-1:0]  cnt_inc;

  logic [MODE_W-1:0] tgt;
  logic [MODE_W-1:0] nxt;
  logic              go;
  logic              en;
  logic [CNT_W-1:0]  cnt;
  logic              passed;
  logic              tmo;

  // Limit of the current mode in milliseconds.
  always_comb begin
    case (state_i.mode)
      MODE_PRIME:         sec_sel = cfg_i.prime_s;
      MODE_RUN, MODE_MIX: sec_sel = cfg_i.run_s;
      MODE_BLOW:          sec_sel = cfg_i.blow_s;
      MODE_OPEN:          sec_sel = cfg_i.open_s;
      default:            sec_sel = '0;
    endcase
  end

  assign limit = (state_i.mode == MODE_CLOSE) ? CMP_W'(cfg_i.close_ms)
                                              : CMP_W'(sec_sel) * CMP_W'(MS_PER_SECOND);
  assign has_limit = !(state_i.mode inside {MODE_IDLE, MODE_DIS});
  assign cnt_inc   = (state_i.elapsed == '1) ? state_i.elapsed
                                             : state_i.elapsed + CNT_W'(1);

  always_comb begin
    en     = state_i.enabled;
    cnt    = state_i.elapsed;
    tgt    = state_i.mode;
    nxt    = state_i.mode;
    go     = 1'b1;
    passed = 1'b0;
    tmo    = 1'b0;

    // Decode the word into a target mode.
    case (item_i.op)
      OP_TICK: begin
        cnt = cnt_inc;
      end
      OP_START: begin
        if (item_i.reenable) begin
          en = 1'b1;
        end
        go  = en;
        tgt = MODE_PRIME;
      end
      OP_STOP: begin
        if (item_i.reenable) begin
          en = 1'b1;
        end
        if (state_i.mode == MODE_RUN) begin
          tgt = MODE_BLOW;
        end else if (!(state_i.mode inside {MODE_IDLE, MODE_DIS}) ||
                     (state_i.mode == MODE_DIS && item_i.reenable)) begin
          tgt = MODE_CLOSE;
        end else begin
          go = 1'b0;
        end
      end
      OP_DISABLE: begin
        en  = 1'b0;
        tgt = (state_i.mode == MODE_RUN) ? MODE_BLOW : MODE_CLOSE;
      end
      OP_BLOWOFF: tgt = MODE_BLOW;
      OP_MIX:     tgt = MODE_MIX;
      OP_BYP_ON:  tgt = item_i.keep_open ? MODE_OPEN : MODE_BLOW;
      default:    tgt = MODE_CLOSE;
    endcase

    if (go) begin
      if (tgt != state_i.mode) begin
        nxt = tgt;
      end else begin
        // Staying in the current mode: check its limit with the counter kept.
        if (state_i.mode == MODE_MIX) begin
          en = 1'b1;
        end
        passed = has_limit && (CMP_W'(cnt) > limit);
        if (passed) begin
          case (state_i.mode)
            MODE_PRIME: nxt = MODE_RUN;
            MODE_RUN: begin
              en  = 1'b0;
              tmo = 1'b1;
              nxt = MODE_BLOW;
            end
            MODE_CLOSE: nxt = en ? MODE_IDLE : MODE_DIS;
            default:    nxt = MODE_CLOSE;
          endcase
        end
      end
      if (nxt != state_i.mode) begin
        cnt = '0;
        en  = entry_enable(nxt, en);
      end
    end
  end

  assign state_o.mode    = nxt;
  assign state_o.enabled = en;
  assign state_o.elapsed = cnt;

  assign res_o.mode         = nxt;
  assign res_o.pump_drive   = nxt inside {MODE_PRIME, MODE_RUN, MODE_MIX};
  assign res_o.bypass_drive = nxt inside {MODE_PRIME, MODE_BLOW, MODE_OPEN, MODE_MIX};
  assign res_o.enabled      = en;
  assign res_o.timed_out    = tmo;

endmodule

`default_nettype wire

### hw/rtl/pump_bypass_sequencer.sv
// Top level of the pump and bypass sequencer: stream ports, state and result registers.
//
// The block drives a pump and a bypass valve through eight modes. Each word on
// the input stream is either a 1 ms tick or a command; every accepted input
// word produces exactly one result word on the output stream, in order. The
// result carries the new mode, both drive bits, the enable flag and a flag
// that marks a run timeout taken on that word.
// A word is taken into an input register, then the mode logic updates the
// mode, enable flag and the saturating millisecond counter while loading the
// result register. A new word is accepted every cycle, limited only by output
// stalls. While the receiver stalls, the result register holds its word, the
// input register still takes one more word, and then tready drops until the
// result moves on. Limits in seconds are scaled by 1000 with one constant
// multiply ahead of the compare.
// Configuration writes are always ready and take effect on the next cycle;
// they are to be issued only while no word is in flight.
// Reset returns all limits to their defaults, the mode to idle with the pump
// enabled, the counter to zero, and empties both registers.
`default_nettype none

module pump_bypass_sequencer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input stream; tdata from bit 0: op[2:0], reenable, keep_open, zero fill.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [pbs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Output stream; tdata from bit 0: mode[2:0], pump_drive, bypass_drive,
  // enabled, timed_out, zero fill.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [pbs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // Configuration write channel.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pbs_pkg::IDX_W-1:0]      cfg_index_i,
  input  wire logic [pbs_pkg::CFG_W-1:0]      cfg_data_i
);
  import pbs_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    out_vld_q;
  logic    out_free;
  logic    step;

  assign cfg_ready_o = 1'b1;

  pbs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The result register can take a word when empty or being drained.
  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.op        <= s_axis_tdata[OP_W-1:0];
      in_q.reenable  <= s_axis_tdata[OP_W];
      in_q.keep_open <= s_axis_tdata[OP_W+1];
    end
  end

  pbs_mode_logic u_logic (
    .state_i (state_q),
    .item_i  (in_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= MODE_IDLE;
      state_q.enabled <= 1'b1;
      state_q.elapsed <= '0;
    end else if (step) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, res_q.timed_out, res_q.enabled,
                          res_q.bypass_drive, res_q.pump_drive, res_q.mode};

  // A run timeout always lands in blowoff with the pump disabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.timed_out) |-> (res_q.mode == MODE_BLOW && !res_q.enabled))
    else $error("timeout result not in blowoff with enable cleared");

  // Disabled mode never holds a set enable flag, idle never a cleared one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_DIS) |-> !state_q.enabled)
    else $error("disabled mode with enable flag set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_IDLE) |-> state_q.enabled)
    else $error("idle mode with enable flag cleared");

  // State moves only when a word is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> ($stable(state_q.mode) && $stable(state_q.elapsed)))
    else $error("sequencer state changed without a word");

  // Entering a new mode always clears the millisecond counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && state_d.mode != state_q.mode) |=> (state_q.elapsed == '0))
    else $error("counter not cleared on mode entry");

endmodule

`default_nettype wire

### dv/pump_bypass_sequencer_test.sv
// Self-checking testbench for the pump and bypass sequencer: directed script plus random traffic.
`timescale 1ns / 100ps

module pump_bypass_sequencer_test;
  import pbs_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RUN_LIMIT_NS = 20_000_000;
  localparam int unsigned MAX_REPORTS  = 10;

  // An index that maps to no register; the block must ignore writes to it.
  localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Result words that can be read straight off the mode table.
  localparam result_t RES_NONE     = '0;
  localparam result_t RES_IDLE     = '{MODE_IDLE, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam result_t RES_PRIME    = '{MODE_PRIME, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam result_t RES_TIMEOUT  = '{MODE_BLOW, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam result_t RES_DISABLED = '{MODE_DIS, 1'b0, 1'b0, 1'b0, 1'b0};

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  // One line of the directed script: either an input word (with an optional
  // hand-written expectation) or a register write.
  typedef struct packed {
    row_kind_e        kind;
    item_t            word;
    logic             typed;
    result_t          want;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
  } script_row_t;

  localparam int unsigned NUM_ROWS = 35;

  // The script walks every command except blowoff, the start-while-disabled and
  // stop-from-idle cases, a run timeout, the limit re-check on a repeated
  // command, zero limits, and writes to the reset-only bit and to an unused index.
  localparam script_row_t SCRIPT [NUM_ROWS] = '{
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b1, RES_IDLE, '0, '0},
    '{ROW_WORD, '{OP_STOP, 1'b0, 1'b0}, 1'b1, RES_IDLE, '0, '0},
    '{ROW_WORD, '{OP_START, 1'b0, 1'b0}, 1'b1, RES_PRIME, '0, '0},
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_REG, '0, 1'b0, RES_NONE, CFG_PRIME_S, 16'd0},
    '{ROW_WORD, '{OP_START, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_STOP, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_START, 1'b1, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_REG, '0, 1'b0, RES_NONE, CFG_RUN_S, 16'd0},
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b1, RES_TIMEOUT, '0, '0},
    '{ROW_REG, '0, 1'b0, RES_NONE, CFG_BLOW_S, 16'd0},
    '{ROW_REG, '0, 1'b0, RES_NONE, CFG_CLOSE_MS, 16'd0},
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b1, RES_DISABLED, '0, '0},
    '{ROW_WORD, '{OP_START, 1'b0, 1'b0}, 1'b1, RES_DISABLED, '0, '0},
    '{ROW_WORD, '{OP_STOP, 1'b0, 1'b0}, 1'b1, RES_DISABLED, '0, '0},
    '{ROW_WORD, '{OP_DISABLE, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_STOP, 1'b1, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b1, RES_IDLE, '0, '0},
    '{ROW_WORD, '{OP_DISABLE, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_START, 1'b1, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_DISABLE, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_MIX, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_TICK, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_BYP_ON, 1'b0, 1'b1}, 1'b0, RES_NONE, '0, '0},
    '{ROW_REG, '0, 1'b0, RES_NONE, CFG_OPEN_S, 16'd0},
    '{ROW_WORD, '{OP_BYP_ON, 1'b0, 1'b1}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_BYP_ON, 1'b0, 1'b0}, 1'b0, RES_NONE, '0, '0},
    '{ROW_WORD, '{OP_MIX, 1'b1, 1'b1}, 1'b0, RES_NONE, '0, '0},
    '{ROW_REG, '0, 1'b0, RES_NONE, CFG_EN_AT_RST, 16'd0},
    '{ROW_REG, '0, 1'b0, RES_NONE, CFG_UNUSED, 16'hFFFF},
    '{ROW_WORD, '{OP_BYP_OFF, 1'b1, 1'b1}, 1'b0, RES_NONE, '0, '0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [IDX_W-1:0]      cfg_index_i   = '0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;

  // Shadow copy of the sequencer: mode, enable flag, millisecond counter and limits.
  logic [MODE_W-1:0] seq_mode     = MODE_IDLE;
  logic              seq_en       = 1'b1;
  logic [CNT_W-1:0]  seq_ms       = '0;
  logic              seq_timeout  = 1'b0;
  logic              seq_en_reset = 1'b1;  // only matters at reset, which happens once
  cfg_t              seq_limits   = '{PRIME_S_RST, RUN_S_RST, BLOW_S_RST, OPEN_S_RST,
                                      CLOSE_MS_RST};

  result_t     expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned words_checked  = 0;

  // Sender pacing: burst length left, and whether gaps are off for this stretch.
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;

  // Receiver stall pattern, replayed one bit per cycle and reloaded after its last bit.
  logic [31:0] ready_pattern = '1;
  int unsigned pattern_pos   = 0;

  pump_bypass_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow sequencer
  // ---------------------------------------------------------------------------

  function automatic logic [47:0] seconds_to_ms(input logic [CFG_W-1:0] s);
    return 48'(s) * 48'(MS_PER_SECOND);
  endfunction

  // Entering a mode restarts the counter; idle, running and mix set the enable
  // flag, disabled clears it.
  function automatic void enter_mode(input logic [MODE_W-1:0] m);
    seq_ms   = '0;
    seq_mode = m;
    if (m == MODE_IDLE || m == MODE_RUN || m == MODE_MIX) begin
      seq_en = 1'b1;
    end else if (m == MODE_DIS) begin
      seq_en = 1'b0;
    end
  endfunction

  // Asking for the current mode keeps the counter and re-checks its limit.
  // Limits are strict: the mode moves on only once the counter exceeds them.
  function automatic void request_mode(input logic [MODE_W-1:0] m);
    logic [47:0] ms;
    if (m != seq_mode) begin
      enter_mode(m);
      return;
    end
    ms = 48'(seq_ms);
    case (seq_mode)
      MODE_PRIME: begin
        if (ms > seconds_to_ms(seq_limits.prime_s)) enter_mode(MODE_RUN);
      end
      MODE_RUN: begin
        if (ms > seconds_to_ms(seq_limits.run_s)) begin
          seq_en      = 1'b0;
          seq_timeout = 1'b1;
          enter_mode(MODE_BLOW);
        end
      end
      MODE_BLOW: begin
        if (ms > seconds_to_ms(seq_limits.blow_s)) enter_mode(MODE_CLOSE);
      end
      MODE_OPEN: begin
        if (ms > seconds_to_ms(seq_limits.open_s)) enter_mode(MODE_CLOSE);
      end
      MODE_CLOSE: begin
        if (ms > 48'(seq_limits.close_ms)) enter_mode(seq_en ? MODE_IDLE : MODE_DIS);
      end
      MODE_MIX: begin
        seq_en = 1'b1;
        if (ms > seconds_to_ms(seq_limits.run_s)) enter_mode(MODE_CLOSE);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic result_t step_sequencer(input item_t w);
    result_t r;
    seq_timeout = 1'b0;
    case (w.op)
      OP_TICK: begin
        if (seq_ms != '1) seq_ms = seq_ms + 1'b1;
        request_mode(seq_mode);
      end
      OP_START: begin
        if (w.reenable) seq_en = 1'b1;
        if (seq_en) request_mode(MODE_PRIME);
      end
      OP_STOP: begin
        if (w.reenable) seq_en = 1'b1;
        if (seq_mode == MODE_RUN) begin
          request_mode(MODE_BLOW);
        end else if ((seq_mode != MODE_IDLE && seq_mode != MODE_DIS) ||
                     (seq_mode == MODE_DIS && w.reenable)) begin
          request_mode(MODE_CLOSE);
        end
      end
      OP_DISABLE: begin
        seq_en = 1'b0;
        request_mode(seq_mode == MODE_RUN ? MODE_BLOW : MODE_CLOSE);
      end
      OP_BLOWOFF: request_mode(MODE_BLOW);
      OP_MIX:     request_mode(MODE_MIX);
      OP_BYP_ON:  request_mode(w.keep_open ? MODE_OPEN : MODE_BLOW);
      default:    request_mode(MODE_CLOSE);
    endcase
    r.mode         = seq_mode;
    r.pump_drive   = (seq_mode == MODE_PRIME || seq_mode == MODE_RUN || seq_mode == MODE_MIX);
    r.bypass_drive = (seq_mode == MODE_PRIME || seq_mode == MODE_BLOW ||
                      seq_mode == MODE_OPEN || seq_mode == MODE_MIX);
    r.enabled      = seq_en;
    r.timed_out    = seq_timeout;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Presents one word and waits for it to be taken. The expectation is queued
  // at the accepting edge; a typed-in expectation replaces the predicted one,
  // but the shadow state advances either way.
  task automatic send_word(input item_t w, input logic typed, input result_t want);
    result_t predicted;
    s_axis_tdata  <= IN_DATA_W'({w.keep_open, w.reenable, w.op});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predicted = step_sequencer(w);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Bursts of random length separated by random gaps, unless steady.
  task automatic pace();
    int unsigned gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    gap        = $urandom_range(1, 8);
    s_axis_tvalid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic send_ticks(input int unsigned count);
    item_t w;
    repeat (count) begin
      w.op        = OP_TICK;
      w.reenable  = 1'($urandom_range(0, 1));
      w.keep_open = 1'($urandom_range(0, 1));
      send_word(w, 1'b0, RES_NONE);
      pace();
    end
  endtask

  // Holds the input stream off until every expected word is back, then lets
  // the two-stage pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; the strobe is dropped afterwards so that
  // back-to-back writes never assign it twice in one step.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PRIME_S:   seq_limits.prime_s  = data;
      CFG_RUN_S:     seq_limits.run_s    = data;
      CFG_BLOW_S:    seq_limits.blow_s   = data;
      CFG_OPEN_S:    seq_limits.open_s   = data;
      CFG_CLOSE_MS:  seq_limits.close_ms = data;
      CFG_EN_AT_RST: seq_en_reset        = data[0];
      default: begin
      end
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_limits(input logic [CFG_W-1:0] prime_s, input logic [CFG_W-1:0] run_s,
                                input logic [CFG_W-1:0] blow_s, input logic [CFG_W-1:0] open_s,
                                input logic [CFG_W-1:0] close_ms);
    drain();
    write_reg(CFG_PRIME_S, prime_s);
    write_reg(CFG_RUN_S, run_s);
    write_reg(CFG_BLOW_S, blow_s);
    write_reg(CFG_OPEN_S, open_s);
    write_reg(CFG_CLOSE_MS, close_ms);
  endtask

  // Random traffic: mostly single commands and ticks, with runs of ticks long
  // enough to carry the short limits, and now and then a full drain.
  task automatic random_phase(input int unsigned count);
    item_t       w;
    int unsigned sent;
    int unsigned run;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        run = $urandom_range(1, 40);
        send_ticks(run);
        sent += run;
      end else begin
        w.op        = ($urandom_range(0, 99) < 45) ? OP_TICK
                                                   : OP_W'($urandom_range(OP_START, OP_BYP_OFF));
        w.reenable  = ($urandom_range(0, 3) == 0);
        w.keep_open = 1'($urandom_range(0, 1));
        send_word(w, 1'b0, RES_NONE);
        pace();
        sent++;
      end
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side and checking
  // ---------------------------------------------------------------------------

  function automatic void report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endfunction

  function automatic void check_result(input logic [OUT_DATA_W-1:0] d);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result word %h arrived with nothing expected", d));
      return;
    end
    want = expected_results.pop_front();
    if (d[MODE_W-1:0] !== want.mode || d[MODE_W] !== want.pump_drive ||
        d[MODE_W+1] !== want.bypass_drive || d[MODE_W+2] !== want.enabled ||
        d[MODE_W+3] !== want.timed_out) begin
      report_mismatch($sformatf(
          "word %0d mode %0d/%0d pump %b/%b bypass %b/%b enabled %b/%b timeout %b/%b",
          words_checked, want.mode, d[MODE_W-1:0], want.pump_drive, d[MODE_W],
          want.bypass_drive, d[MODE_W+1], want.enabled, d[MODE_W+2],
          want.timed_out, d[MODE_W+3]));
    end
    words_checked++;
  endfunction

  // Output words are taken on edges where valid and ready were both high before
  // the edge; ready for the next cycle comes from the stall pattern.
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) check_result(m_axis_tdata);
    m_axis_tready <= ready_pattern[pattern_pos];
    if (pattern_pos == 31) begin
      pattern_pos = 0;
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = $urandom | 32'h1111_1111;
        2:       ready_pattern = ($urandom & $urandom) | 32'h8000_0001;
        default: ready_pattern = 32'hF0F0_3C3C;
      endcase
    end else begin
      pattern_pos++;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script, starting from the reset defaults.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (SCRIPT[i].kind == ROW_REG) begin
        drain();
        write_reg(SCRIPT[i].idx, SCRIPT[i].data);
      end else begin
        send_word(SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].want);
        pace();
      end
    end

    // Lowest limits, sender without gaps: every tick in a timed mode moves on.
    program_limits('0, '0, '0, '0, '0);
    steady = 1'b1;
    random_phase(120);
    steady = 1'b0;

    // Highest limits; nothing times out, so only commands change the mode.
    program_limits('1, '1, '1, '1, '1);
    write_reg(CFG_EN_AT_RST, 16'd1);
    write_reg(CFG_UNUSED, 16'h5A5A);
    random_phase(100);

    // Short random limits, so ticks reach the closing delay and the zero limits.
    repeat (3) begin
      program_limits(($urandom_range(0, 3) == 0) ? 16'd1 : 16'd0,
                     ($urandom_range(0, 3) == 0) ? 16'd1 : 16'd0,
                     ($urandom_range(0, 3) == 0) ? 16'd1 : 16'd0,
                     ($urandom_range(0, 3) == 0) ? 16'd1 : 16'd0,
                     CFG_W'($urandom_range(0, 30)));
      random_phase(50);
    end

    // One-second limits: runs of ticks well short of a second must leave
    // priming, a held bypass and a mix in place, since the limits are counted
    // in milliseconds.
    program_limits(16'd1, 16'd1, 16'd1, 16'd1, CFG_W'($urandom_range(0, 30)));
    send_word('{OP_START, 1'b1, 1'b0}, 1'b0, RES_NONE);
    send_ticks(60);
    send_word('{OP_BYP_ON, 1'b0, 1'b1}, 1'b0, RES_NONE);
    send_ticks(30);
    send_word('{OP_MIX, 1'b0, 1'b0}, 1'b0, RES_NONE);
    send_ticks(30);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("pump_bypass_sequencer verification clean");
    end else begin
      $display("pump_bypass_sequencer verification failed");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT_NS);
    $display("pump_bypass_sequencer verification failed");
    $finish;
  end

endmodule
